[sv/c5s_pkg.sv]
// ----------------------------------------------------------------------------
// c5s_pkg
// Shared types and constants for the streaming 5x5 convolution block.
// ----------------------------------------------------------------------------
package c5s_pkg;

  localparam int LineMax        = 1024;
  localparam int LineAddrW      = $clog2(LineMax);
  localparam int CntW           = LineAddrW + 1;
  localparam int MaskSize       = 5;
  localparam int Taps           = MaskSize * MaskSize;
  localparam int StoredRows     = MaskSize - 1;
  localparam int WeightW        = 12;
  localparam int WeightFracBits = 10;
  localparam int RowW           = WeightW * MaskSize;
  localparam int ProdW          = WeightW + 9;
  localparam int SumW           = ProdW + $clog2(Taps);
  localparam int RamW           = StoredRows * 8;

  // configuration register indexes
  typedef enum logic [2:0] {
    CfgFrameWidth  = 3'd0,
    CfgFrameHeight = 3'd1,
    CfgWDyPlus2    = 3'd2,
    CfgWDyPlus1    = 3'd3,
    CfgWDyZero     = 3'd4,
    CfgWDyMinus1   = 3'd5,
    CfgWDyMinus2   = 3'd6
  } c5s_cfg_e;

  typedef struct packed {
    logic [7:0] pixel_in;
    logic       frame_start;
  } c5s_in_t;

  typedef struct packed {
    logic [7:0]  pixel_out;
    logic [9:0]  centre_x;
    logic [15:0] centre_y;
    logic        clamped;
    logic        last_of_frame;
  } c5s_out_t;

  // window [row][col], row 0 = oldest line, col 0 = leftmost
  typedef logic [MaskSize-1:0][MaskSize-1:0][7:0] c5s_win_t;

  // word handed from cell to cell
  typedef struct packed {
    logic                   emit;
    logic                   last;
    logic [9:0]             cx;
    logic [15:0]            cy;
    c5s_win_t               win;
    logic signed [SumW-1:0] sum;
  } c5s_tap_t;

endpackage

[sv/c5s_ram.sv]
// ----------------------------------------------------------------------------
// c5s_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module c5s_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/c5s_cell.sv]
// ----------------------------------------------------------------------------
// c5s_cell
// One tap of the systolic chain: multiply one window pixel by its weight and
// add it to the partial sum travelling with the window.
// ----------------------------------------------------------------------------
module c5s_cell import c5s_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [WeightW-1:0] weight_i,
  input  logic [7:0]         pixel_i,
  input  c5s_tap_t           tap_i,
  output c5s_tap_t           tap_o
);

  logic signed [ProdW-1:0] prod;
  c5s_tap_t                tap_d;
  c5s_tap_t                tap_q;

  // multiply and accumulate
  always_comb begin
    prod      = $signed(weight_i) * $signed({1'b0, pixel_i});
    tap_d     = tap_i;
    tap_d.sum = tap_i.sum + SumW'(prod);
  end

  // advance the word to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q.emit <= 1'b0;
    end else if (en_i) begin
      tap_q <= tap_d;
    end
  end

  assign tap_o = tap_q;

endmodule

[sv/conv5x5_stencil.sv]
// ----------------------------------------------------------------------------
// conv5x5_stencil
// Streaming 5x5 convolution over an 8-bit raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the in channel (valid/ready) in raster order; frame_start
//   marks the first pixel of a frame. Each pixel whose 5x5 neighbourhood lies
//   inside the frame yields one word on the out channel (valid/ready) with the
//   rounded, clamped weighted sum and the centre coordinates. Border pixels
//   yield nothing.
//   The cfg channel writes frame width, height and the five weight rows; it
//   is always ready. It must be written only while the block is idle; the
//   block itself does not enforce this. Throughput is one pixel per cycle
//   while the receiver does not stall. Each pixel passes the read stage,
//   which reads the line store into the first cell, then the chain of
//   multiply-accumulate cells (one tap each), and then the output register.
//   The line store is one RAM of LineMax words, four bytes each, written
//   once per pixel and read for each pixel, re-read while stalled.
//   Reset restores the default geometry and weights and clears the counters;
//   the line store is not cleared. When the receiver stalls, the whole
//   pipeline holds and in_ready_o drops in the same cycle.
// ----------------------------------------------------------------------------
module conv5x5_stencil import c5s_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  c5s_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output c5s_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [59:0] cfg_data_i
);

  // configuration registers
  logic [10:0]    fw_q;
  logic [15:0]    fh_q;
  logic [RowW-1:0] wrow_q [MaskSize];

  // counters
  logic [LineAddrW-1:0] col_q, col_d;
  logic [15:0]          line_q, line_d;

  // read stage
  logic                 s0_valid_q;
  logic                 s0_emit_q, s0_emit_d;
  logic                 s0_last_q, s0_last_d;
  logic [LineAddrW-1:0] s0_x_q, s0_x_d;
  logic [15:0]          s0_y_q, s0_y_d;
  logic [7:0]           s0_pix_q;

  logic                 adv;
  logic                 accept;
  logic [LineAddrW-1:0] raddr;
  logic [RamW-1:0]      rdata;
  logic [RamW-1:0]      wdata;
  logic                 we;

  c5s_win_t win_q, win_d;
  c5s_tap_t chain [Taps];
  c5s_tap_t head;

  logic       out_valid_q;
  c5s_out_t   out_q, out_d;
  logic signed [SumW:0] rnd;
  logic signed [SumW:0] val;

  assign adv         = !out_valid_q || out_ready_i;
  assign in_ready_o  = adv;
  assign accept      = in_valid_i && adv;
  assign cfg_ready_o = 1'b1;

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q      <= 11'd1024;
      fh_q      <= 16'd1024;
      wrow_q[0] <= 60'd0;
      wrow_q[1] <= 60'd1711276032;
      wrow_q[2] <= 60'd7012826374144;
      wrow_q[3] <= 60'd1711276032;
      wrow_q[4] <= 60'd0;
    end else if (cfg_valid_i) begin
      unique case (c5s_cfg_e'(cfg_index_i))
        CfgFrameWidth:  fw_q      <= cfg_data_i[10:0];
        CfgFrameHeight: fh_q      <= cfg_data_i[15:0];
        CfgWDyPlus2:    wrow_q[0] <= cfg_data_i;
        CfgWDyPlus1:    wrow_q[1] <= cfg_data_i;
        CfgWDyZero:     wrow_q[2] <= cfg_data_i;
        CfgWDyMinus1:   wrow_q[3] <= cfg_data_i;
        CfgWDyMinus2:   wrow_q[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // locate the incoming pixel and advance the counters
  always_comb begin
    logic [CntW-1:0] w;
    logic [15:0]     h;
    logic [CntW-1:0] cc;
    logic [16:0]     lc;
    logic [CntW-1:0] nc;
    logic [16:0]     nl;
    if (32'(fw_q) >= LineMax) begin
      w = CntW'(LineMax);
    end else if (fw_q < 11'd5) begin
      w = CntW'(5);
    end else begin
      w = CntW'(fw_q);
    end
    h  = (fh_q < 16'd5) ? 16'd5 : fh_q;
    cc = in_data_i.frame_start ? '0 : CntW'(col_q);
    lc = in_data_i.frame_start ? '0 : {1'b0, line_q};
    if (cc >= w) begin
      cc = '0;
      lc = lc + 17'd1;
    end
    if (lc >= {1'b0, h}) begin
      lc = '0;
    end
    s0_x_d = cc[LineAddrW-1:0];
    s0_y_d = lc[15:0];
    nc     = cc + CntW'(1);
    nl     = lc;
    if (nc >= w) begin
      nc = '0;
      nl = lc + 17'd1;
      if (nl >= {1'b0, h}) begin
        nl = '0;
      end
    end
    col_d     = nc[LineAddrW-1:0];
    line_d    = nl[15:0];
    s0_emit_d = (cc >= CntW'(MaskSize - 1)) && (lc >= 17'(MaskSize - 1));
    s0_last_d = (cc == w - CntW'(1)) && (lc[15:0] == h - 16'd1);
  end

  // hold counters and the read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      line_q     <= '0;
      s0_valid_q <= 1'b0;
    end else if (adv) begin
      s0_valid_q <= in_valid_i;
      if (in_valid_i) begin
        col_q  <= col_d;
        line_q <= line_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_emit_q <= s0_emit_d;
      s0_last_q <= s0_last_d;
      s0_x_q    <= s0_x_d;
      s0_y_q    <= s0_y_d;
      s0_pix_q  <= in_data_i.pixel_in;
    end
  end

  // re-read the held column while stalled
  assign raddr = accept ? s0_x_d : s0_x_q;

  c5s_ram #(
    .Width (RamW),
    .Depth (LineMax)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (s0_x_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // shift the window and load the new column
  always_comb begin
    logic [1:0] slot;
    win_d = win_q;
    wdata = rdata;
    for (int r = 0; r < MaskSize; r++) begin
      for (int c = 0; c < MaskSize - 1; c++) begin
        win_d[r][c] = win_q[r][c+1];
      end
    end
    for (int r = 0; r < StoredRows; r++) begin
      slot = s0_y_q[1:0] + 2'(r);
      win_d[r][MaskSize-1] = rdata[8*slot +: 8];
    end
    win_d[MaskSize-1][MaskSize-1] = s0_pix_q;
    wdata[8*s0_y_q[1:0] +: 8]     = s0_pix_q;
  end

  assign we = s0_valid_q && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (we) begin
      win_q <= win_d;
    end
  end

  // start the word for the cell chain
  always_comb begin
    head      = '0;
    head.emit = s0_valid_q && s0_emit_q;
    head.last = s0_last_q;
    head.cx   = 10'(s0_x_q - LineAddrW'(2));
    head.cy   = s0_y_q - 16'd2;
    head.win  = win_d;
    head.sum  = '0;
  end

  // chain of multiply-accumulate cells, one per tap
  for (genvar k = 0; k < Taps; k++) begin : g_cell
    localparam int R = k / MaskSize;
    localparam int C = k % MaskSize;
    c5s_tap_t   tap_in;
    logic [7:0] pix;
    if (k == 0) begin : g_head
      assign tap_in = head;
    end else begin : g_link
      assign tap_in = chain[k-1];
    end
    assign pix = tap_in.win[R][C];
    c5s_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (adv),
      .weight_i (wrow_q[MaskSize-1-R][WeightW*C +: WeightW]),
      .pixel_i  (pix),
      .tap_i    (tap_in),
      .tap_o    (chain[k])
    );
  end

  // round, shift and clamp
  always_comb begin
    rnd = (SumW+1)'(chain[Taps-1].sum) + (SumW+1)'(1 << (WeightFracBits - 1));
    val = rnd >>> WeightFracBits;
    out_d.centre_x      = chain[Taps-1].cx;
    out_d.centre_y      = chain[Taps-1].cy;
    out_d.last_of_frame = chain[Taps-1].last;
    if (rnd[SumW]) begin
      out_d.pixel_out = 8'd0;
      out_d.clamped   = 1'b1;
    end else if (val > (SumW+1)'(255)) begin
      out_d.pixel_out = 8'd255;
      out_d.clamped   = 1'b1;
    end else begin
      out_d.pixel_out = val[7:0];
      out_d.clamped   = 1'b0;
    end
  end

  // hold the result word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= chain[Taps-1].emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
